// ===== rtl/sipq_pkg.sv =====
// Shared types and field layout for the sorted-insert priority queue.
package sipq_pkg;

  localparam int KEY_BITS   = 32;
  localparam int IN_TAG_W   = 16;
  localparam int OUT_TAG_W  = 16;
  localparam int OUT_CNT_W  = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== rtl/sipq_cell.sv =====
// One storage cell of the sorted chain: holds a key, a tag and a valid bit.
module sipq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sipq_pkg::cell_ctl_t  ctl,
  input  sipq_pkg::key_t       new_key,
  input  logic [TAG_BITS-1:0]  new_tag,
  input  logic                 left_keep,
  input  logic                 left_valid,
  input  sipq_pkg::key_t       left_key,
  input  logic [TAG_BITS-1:0]  left_tag,
  input  logic                 right_valid,
  input  sipq_pkg::key_t       right_key,
  input  logic [TAG_BITS-1:0]  right_tag,
  output logic                 keep,
  output logic                 valid,
  output sipq_pkg::key_t       key,
  output logic [TAG_BITS-1:0]  tag,
  output logic                 valid_nxt,
  output logic [TAG_BITS-1:0]  tag_nxt
);

  logic                valid_r;
  sipq_pkg::key_t      key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r;

  // equal keys stay ahead of the new entry
  assign keep = valid_r && (key_r <= new_key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctl.pop) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
      tag_nxt   = right_tag;
    end else if (ctl.push && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        tag_nxt   = new_tag;
      end else begin
        valid_nxt = left_valid;
        key_nxt   = left_key;
        tag_nxt   = left_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign tag   = tag_r;

endmodule

// ===== rtl/sorted_insert_priority_queue.sv =====
// Top level: bounded min-priority queue built as a chain of sorted cells.
//
//  channel | direction | transfer when          | contents
//  in_     | slave     | in_tvalid & in_tready  | tuser func; tdata key, tag
//  out_    | master    | out_tvalid & out_tready| tdata result flags, head tag, count
//
// One item per cycle while out_ is not stalled: every cell compares its key with the pushed key in the same
// cycle and loads from itself, its neighbour or the input; that compare sets it.
// The result appears on out_ the cycle after the input transfer.
// Reset (synchronous, active low) empties the queue and the output register.
// A stalled output holds its result; a new item is taken in the cycle it is read.
module sorted_insert_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,  // func
  input  logic [sipq_pkg::IN_DATA_W-1:0]  in_tdata,  // key[31:0], tag[47:32]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_tag[15:0], popped_valid[16], was_empty[17], dropped[18],
  // head_tag[34:19], count[39:35]
  output logic [sipq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                in_acc;
  logic                is_pop, full, empty;
  sipq_pkg::cell_ctl_t ctl;
  sipq_pkg::key_t      new_key;
  logic [TAG_BITS-1:0] new_tag;
  logic [CW-1:0]       count_r, count_nxt;

  logic                keep_w      [DEPTH];
  logic                valid_w     [DEPTH];
  sipq_pkg::key_t      key_w       [DEPTH];
  logic [TAG_BITS-1:0] tag_w       [DEPTH];
  logic                valid_nxt_w [DEPTH];
  logic [TAG_BITS-1:0] tag_nxt_w   [DEPTH];

  logic                                out_valid_r;
  logic [sipq_pkg::OUT_DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [sipq_pkg::OUT_TAG_W-1:0]      popped_tag, head_tag;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_pop    = (in_tuser == sipq_pkg::FUNC_POP);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign new_key   = in_tdata[31:0];
  assign new_tag   = TAG_BITS'(in_tdata[47:32]);

  assign ctl.push = in_acc && !is_pop && !full;
  assign ctl.pop  = in_acc && is_pop && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                left_keep, left_valid, right_valid;
      sipq_pkg::key_t      left_key, right_key;
      logic [TAG_BITS-1:0] left_tag, right_tag;

      if (gi == 0) begin : g_head
        assign left_keep  = 1'b1;
        assign left_valid = 1'b1;
        assign left_key   = new_key;
        assign left_tag   = new_tag;
      end else begin : g_mid
        assign left_keep  = keep_w[gi-1];
        assign left_valid = valid_w[gi-1];
        assign left_key   = key_w[gi-1];
        assign left_tag   = tag_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_valid = 1'b0;
        assign right_key   = new_key;
        assign right_tag   = new_tag;
      end else begin : g_body
        assign right_valid = valid_w[gi+1];
        assign right_key   = key_w[gi+1];
        assign right_tag   = tag_w[gi+1];
      end

      sipq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_key     (new_key),
        .new_tag     (new_tag),
        .left_keep   (left_keep),
        .left_valid  (left_valid),
        .left_key    (left_key),
        .left_tag    (left_tag),
        .right_valid (right_valid),
        .right_key   (right_key),
        .right_tag   (right_tag),
        .keep        (keep_w[gi]),
        .valid       (valid_w[gi]),
        .key         (key_w[gi]),
        .tag         (tag_w[gi]),
        .valid_nxt   (valid_nxt_w[gi]),
        .tag_nxt     (tag_nxt_w[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign popped_tag = ctl.pop ? sipq_pkg::OUT_TAG_W'(tag_w[0]) : '0;
  assign head_tag   = valid_nxt_w[0] ? sipq_pkg::OUT_TAG_W'(tag_nxt_w[0]) : '0;

  assign out_data_nxt = {
    sipq_pkg::OUT_CNT_W'(count_nxt),
    head_tag,
    in_acc && !is_pop && full,
    in_acc && is_pop && empty,
    ctl.pop,
    popped_tag
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sorted_insert_priority_queue_tb.sv =====
// Self-checking testbench for the sorted-insert priority queue with random traffic and stalls.
module sorted_insert_priority_queue_tb;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 1000;
  localparam int CALM_TAIL   = 100;

  typedef struct {
    logic             func;
    sipq_pkg::key_t   key;
    logic [15:0]      tag;
  } queue_op_t;

  typedef struct {
    logic [15:0] popped_tag;
    logic        popped_valid;
    logic        was_empty;
    logic        dropped;
    logic [15:0] head_tag;
    logic [4:0]  count;
  } queue_resp_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic                            in_tuser = 1'b0;
  logic [sipq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sipq_pkg::OUT_DATA_W-1:0] out_tdata;

  queue_op_t   op_backlog[$];
  queue_resp_t expected_resps[$];

  sipq_pkg::key_t model_keys[QDEPTH];
  logic [15:0]    model_tags[QDEPTH];
  int             model_fill = 0;

  queue_op_t cur_op;
  bit        cur_loaded = 0;
  bit        in_taken = 0;
  bit        random_loaded = 0;
  bit        mismatch = 0;
  int        send_idle = 0;
  int        recv_stall = 0;
  int        cycles = 0;

  sorted_insert_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),   // func
    .in_tdata  (in_tdata),   // key[31:0], tag[47:32]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // popped_tag, popped_valid, was_empty, dropped, head_tag, count
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit calm();
    return random_loaded && (op_backlog.size() < CALM_TAIL);
  endfunction

  task automatic add_op(input queue_op_t op);
    op_backlog.insert(op_backlog.size(), op);
  endtask

  // Sorted-list update; equal keys go behind the stored ones.
  task automatic apply_op(input queue_op_t op, output queue_resp_t r);
    int pos;
    r = '{default: '0};
    if (op.func == sipq_pkg::FUNC_PUSH) begin
      if (model_fill >= QDEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < model_fill && model_keys[pos] <= op.key) pos++;
        for (int i = model_fill; i > pos; i--) begin
          model_keys[i] = model_keys[i-1];
          model_tags[i] = model_tags[i-1];
        end
        model_keys[pos] = op.key;
        model_tags[pos] = op.tag;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.was_empty = 1'b1;
      end else begin
        r.popped_tag   = model_tags[0];
        r.popped_valid = 1'b1;
        for (int i = 1; i < model_fill; i++) begin
          model_keys[i-1] = model_keys[i];
          model_tags[i-1] = model_tags[i];
        end
        model_fill--;
      end
    end
    if (model_fill > 0) r.head_tag = model_tags[0];
    r.count = model_fill[4:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatch = 1;
    end
  endtask

  function automatic sipq_pkg::key_t pick_key();
    sipq_pkg::key_t corners[7] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                                   32'h1, 32'h2, 32'h00010000};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 6)];
    return sipq_pkg::key_t'($urandom);
  endfunction

  function automatic queue_op_t make_op(logic func, sipq_pkg::key_t key, logic [15:0] tag);
    queue_op_t op;
    op.func = func;
    op.key  = key;
    op.tag  = tag;
    return op;
  endfunction

  // Monitor: check result transfers first, then predict the accepted input.
  always @(posedge clk) begin
    queue_resp_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_resps.size() == 0) begin
          $error("result transfer with nothing expected: 0x%0h", out_tdata);
          mismatch = 1;
        end else begin
          exp_r = expected_resps.pop_front();
          check_field("popped_tag",   exp_r.popped_tag,   out_tdata[15:0]);
          check_field("popped_valid", exp_r.popped_valid, out_tdata[16]);
          check_field("was_empty",    exp_r.was_empty,    out_tdata[17]);
          check_field("dropped",      exp_r.dropped,      out_tdata[18]);
          check_field("head_tag",     exp_r.head_tag,     out_tdata[34:19]);
          check_field("count",        exp_r.count,        out_tdata[39:35]);
        end
      end
      if (in_tvalid && in_tready) begin
        apply_op(cur_op, exp_r);
        expected_resps.insert(expected_resps.size(), exp_r);
        in_taken = 1;
      end
    end
  end

  // Driver: valid is held until the transfer; idle bursts only between items.
  always @(negedge clk) begin
    if (in_taken) begin
      cur_loaded = 0;
      in_taken   = 0;
    end
    if (!cur_loaded) begin
      if (send_idle > 0) begin
        send_idle--;
      end else if (!calm() && op_backlog.size() > 0 && $urandom_range(0, 7) == 0) begin
        send_idle = $urandom_range(1, 12) - 1;
      end else if (op_backlog.size() > 0) begin
        cur_op     = op_backlog.pop_front();
        cur_loaded = 1;
      end
    end
    in_tvalid <= cur_loaded;
    in_tuser  <= cur_loaded ? cur_op.func : 1'b0;
    in_tdata  <= cur_loaded ? {cur_op.tag, cur_op.key} : '0;
  end

  always @(negedge clk) begin
    logic rdy;
    if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else if (!calm() && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_tready <= rdy;
  end

  initial begin : stimulus
    int n;
    int len;
    int push_pct;
    queue_op_t op;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, key extremes, ties, drain back past empty.
    add_op(make_op(sipq_pkg::FUNC_POP,  32'hffffffff, 16'hffff));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h7fffffff, 16'hffff));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h80000000, 16'h0000));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h00000000, 16'h0001));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'hffffffff, 16'h0002));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h00000000, 16'h0003));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h7fffffff, 16'h0004));
    add_op(make_op(sipq_pkg::FUNC_PUSH, 32'h00000000, 16'h0005));
    for (int i = 0; i < 9; i++)
      add_op(make_op(sipq_pkg::FUNC_POP, sipq_pkg::key_t'($urandom), 16'($urandom)));

    // hold off until every result is back
    while (op_backlog.size() > 0 || cur_loaded || expected_resps.size() > 0)
      @(posedge clk);

    // Random: fill bursts (mostly pushes), drain bursts (mostly pops), mixed in between.
    n = 0;
    while (n < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_pct = 90;
        4, 5, 6:    push_pct = 10;
        default:    push_pct = 50;
      endcase
      len = $urandom_range(8, 24);
      for (int i = 0; i < len; i++) begin
        op.func = ($urandom_range(0, 99) < push_pct) ? sipq_pkg::FUNC_PUSH : sipq_pkg::FUNC_POP;
        op.key  = pick_key();
        op.tag  = 16'($urandom);
        add_op(op);
        n++;
      end
    end
    random_loaded = 1;

    while (op_backlog.size() > 0 || cur_loaded || expected_resps.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (!mismatch) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
